// File: rtl/rmq_pkg.sv
// Shared types and constants for the rotation-matrix-to-quaternion converter.
`timescale 1ns / 1ps

package rmq_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Which Shepperd branch produced the diagonal-derived component.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

endpackage

// File: rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module rmq_sqrt #(
    parameter int K     = 18,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2*K-1:0]   i_rad,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [K-1:0]     o_root,
    output logic [TAG_W-1:0] o_tag
);

    logic [K+1:0]   r_rem  [K];
    logic [K-1:0]   r_root [K];
    logic [2*K-1:0] r_rad  [K];
    logic [TAG_W-1:0] r_tag [K];
    logic [K-1:0]   r_vld;

    for (genvar g = 0; g < K; g++) begin : g_st
        logic [K+1:0]     rem_p;
        logic [K-1:0]     root_p;
        logic [2*K-1:0]   rad_p;
        logic [TAG_W-1:0] tag_p;
        logic             vld_p;
        logic [K+3:0]     rem_sh;
        logic [K+3:0]     trial;
        logic             take;
        logic [K+1:0]     n_rem;
        logic [K-1:0]     n_root;

        if (g == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = i_rad;
            assign tag_p  = i_tag;
            assign vld_p  = i_valid;
        end else begin : g_next
            assign rem_p  = r_rem[g-1];
            assign root_p = r_root[g-1];
            assign rad_p  = r_rad[g-1];
            assign tag_p  = r_tag[g-1];
            assign vld_p  = r_vld[g-1];
        end

        // Bring down the next two radicand bits and try to subtract 4*root+1.
        assign rem_sh = {rem_p, rad_p[2*K-1 -: 2]};
        assign trial  = (K+4)'({root_p, 2'b01});
        assign take   = (rem_sh >= trial);
        assign n_rem  = take ? (K+2)'(rem_sh - trial) : (K+2)'(rem_sh);
        assign n_root = {root_p[K-2:0], take};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= {rad_p[2*K-3:0], 2'b00};
                r_tag[g]  <= tag_p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_p;
            end
        end
    end

    assign o_valid = r_vld[K-1];
    assign o_root  = r_root[K-1];
    assign o_tag   = r_tag[K-1];

endmodule

// File: rtl/rmq_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module rmq_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 19,
    parameter int Q_W   = 17,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot,
    output logic [TAG_W-1:0] o_tag
);

    // The caller guarantees that the quotient fits in Q_W bits.
    localparam int CW = NUM_W + DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem  [Q_W];
    logic [DEN_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];
    logic [TAG_W-1:0] r_tag  [Q_W];
    logic [Q_W-1:0]   r_vld;

    for (genvar g = 0; g < Q_W; g++) begin : g_st
        localparam int SH = Q_W - 1 - g;
        logic [NUM_W-1:0] rem_p;
        logic [DEN_W-1:0] den_p;
        logic [Q_W-1:0]   quot_p;
        logic [TAG_W-1:0] tag_p;
        logic             vld_p;
        logic [CW-1:0]    rem_w;
        logic [CW-1:0]    dsh;
        logic             take;

        if (g == 0) begin : g_first
            assign rem_p  = i_num;
            assign den_p  = i_den;
            assign quot_p = '0;
            assign tag_p  = i_tag;
            assign vld_p  = i_valid;
        end else begin : g_next
            assign rem_p  = r_rem[g-1];
            assign den_p  = r_den[g-1];
            assign quot_p = r_quot[g-1];
            assign tag_p  = r_tag[g-1];
            assign vld_p  = r_vld[g-1];
        end

        assign rem_w = CW'(rem_p);
        assign dsh   = CW'(den_p) << SH;
        assign take  = (rem_w >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= take ? NUM_W'(rem_w - dsh) : rem_p;
                r_den[g]  <= den_p;
                r_quot[g] <= {quot_p[Q_W-2:0], take};
                r_tag[g]  <= tag_p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_p;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// Top level of the pipelined rotation-matrix-to-unit-quaternion converter.
`timescale 1ns / 1ps

// Converts a 3x3 rotation matrix in signed Q1.FRAC_BITS into a unit quaternion by
// Shepperd's method. It accepts one matrix per clock while the pipeline is not held
// and returns one quaternion per matrix, in order; the pipeline is made of two
// pipelined square roots of FRAC_BITS+2 stages and two banks of pipelined dividers
// of FRAC_BITS+1 stages, plus six registered stages. The whole pipeline holds when
// the output register is full and not taken. quat_w is never negative. When the
// branch radicand or the component norm works out to zero, the identity quaternion
// is returned with degenerate set.

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [FRAC_BITS+1:0] i_m00,
    input  logic signed [FRAC_BITS+1:0] i_m01,
    input  logic signed [FRAC_BITS+1:0] i_m02,
    input  logic signed [FRAC_BITS+1:0] i_m10,
    input  logic signed [FRAC_BITS+1:0] i_m11,
    input  logic signed [FRAC_BITS+1:0] i_m12,
    input  logic signed [FRAC_BITS+1:0] i_m20,
    input  logic signed [FRAC_BITS+1:0] i_m21,
    input  logic signed [FRAC_BITS+1:0] i_m22,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic        [FRAC_BITS:0]   o_quat_w,
    output logic signed [FRAC_BITS+1:0] o_quat_x,
    output logic signed [FRAC_BITS+1:0] o_quat_y,
    output logic signed [FRAC_BITS+1:0] o_quat_z,
    output logic                        o_degenerate
);

    localparam int F     = FRAC_BITS;
    localparam int RW    = F + 5;      // trace and radicand arithmetic
    localparam int DW    = F + 3;      // off-diagonal sums and differences
    localparam int K     = F + 2;      // square root result width
    localparam int CMW   = F + 1;      // component magnitude width
    localparam int SQW   = 2 * F + 2;  // one squared component
    localparam int T1W   = 2 + 3 * DW;
    localparam int T0W   = F + 6;
    localparam int T2W   = 4 * CMW + 5;
    localparam int ONE_I = 1 << F;

    logic en;

    // ---------------- Stage 1: branch choice, radicand, differences
    logic signed [RW-1:0] e00, e11, e22, tr, rr, one_r;
    logic signed [DW-1:0] dd [3];
    rmq_pkg::t_branch     br;

    assign one_r = RW'(ONE_I);
    assign e00   = RW'(i_m00);
    assign e11   = RW'(i_m11);
    assign e22   = RW'(i_m22);
    assign tr    = e00 + e11 + e22;

    always_comb begin
        if (tr > 0) begin
            br    = rmq_pkg::BR_TRACE;
            rr    = one_r + tr;
            dd[0] = DW'(i_m21) - DW'(i_m12);
            dd[1] = DW'(i_m02) - DW'(i_m20);
            dd[2] = DW'(i_m10) - DW'(i_m01);
        end else if (e00 > e11 && e00 > e22) begin
            br    = rmq_pkg::BR_X;
            rr    = one_r + e00 - e11 - e22;
            dd[0] = DW'(i_m21) - DW'(i_m12);
            dd[1] = DW'(i_m01) + DW'(i_m10);
            dd[2] = DW'(i_m02) + DW'(i_m20);
        end else if (e11 > e22) begin
            br    = rmq_pkg::BR_Y;
            rr    = one_r + e11 - e00 - e22;
            dd[0] = DW'(i_m02) - DW'(i_m20);
            dd[1] = DW'(i_m01) + DW'(i_m10);
            dd[2] = DW'(i_m12) + DW'(i_m21);
        end else begin
            br    = rmq_pkg::BR_Z;
            rr    = one_r + e22 - e00 - e11;
            dd[0] = DW'(i_m10) - DW'(i_m01);
            dd[1] = DW'(i_m02) + DW'(i_m20);
            dd[2] = DW'(i_m12) + DW'(i_m21);
        end
    end

    logic [F+2:0]  r_s1_rad;
    logic [T1W-1:0] r_s1_tag;
    logic          r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // A negative radicand is clamped to zero.
            r_s1_rad <= rr[RW-1] ? '0 : rr[F+2:0];
            r_s1_tag <= {2'(br), dd[0], dd[1], dd[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
    end

    // ---------------- First square root: h = floor(sqrt(r * 2^F))
    logic           sq1_vld;
    logic [K-1:0]   sq1_h;
    logic [T1W-1:0] sq1_tag;

    rmq_sqrt #(.K(K), .TAG_W(T1W)) u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_vld),
        .i_rad   ({1'b0, r_s1_rad, {F{1'b0}}}),
        .i_tag   (r_s1_tag),
        .o_valid (sq1_vld),
        .o_root  (sq1_h),
        .o_tag   (sq1_tag)
    );

    // ---------------- Stage 2: divider setup against s = 2h
    logic signed [DW-1:0] s2_d   [3];
    logic        [DW-1:0] s2_mag [3];
    logic                 s2_ovf [3];
    logic        [F+3:0]  two_s;

    assign two_s = {sq1_h, 2'b00};

    for (genvar i = 0; i < 3; i++) begin : g_d
        assign s2_d[i]   = $signed(sq1_tag[(2-i)*DW +: DW]);
        assign s2_mag[i] = s2_d[i][DW-1] ? DW'(-s2_d[i]) : DW'(s2_d[i]);
        // The raw quotient saturates exactly when |d| >= 2s.
        assign s2_ovf[i] = ({1'b0, s2_mag[i]} >= two_s);
    end

    logic [2*F+2:0] r_s2_num [3];
    logic [F+2:0]   r_s2_den;
    logic [2:0]     r_s2_ovf;
    logic [2:0]     r_s2_sgn;
    logic [1:0]     r_s2_diag;
    logic [F:0]     r_s2_hq;
    logic           r_s2_sz;
    logic           r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_num[i] <= s2_ovf[i] ? '0 : {s2_mag[i], {F{1'b0}}};
                r_s2_ovf[i] <= s2_ovf[i];
                r_s2_sgn[i] <= s2_d[i][DW-1];
            end
            r_s2_den  <= (sq1_h == '0) ? (F+3)'(1) : {sq1_h, 1'b0};
            r_s2_diag <= sq1_tag[T1W-1 -: 2];
            r_s2_hq   <= sq1_h[K-1:1];
            r_s2_sz   <= (sq1_h == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= sq1_vld;
        end
    end

    // ---------------- First divider bank: raw components (d * 2^F) / s
    logic [CMW-1:0] dv1_q [3];
    logic [T0W-1:0] dv1_tag0;
    logic [1:0]     dv1_tag1;
    logic [1:0]     dv1_tag2;
    logic           dv1_vld;

    rmq_div #(.NUM_W(2*F+3), .DEN_W(F+3), .Q_W(CMW), .TAG_W(T0W)) u_div_raw0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_num[0]),
        .i_den   (r_s2_den),
        .i_tag   ({r_s2_diag, r_s2_hq, r_s2_sz, r_s2_ovf[0], r_s2_sgn[0]}),
        .o_valid (dv1_vld),
        .o_quot  (dv1_q[0]),
        .o_tag   (dv1_tag0)
    );

    rmq_div #(.NUM_W(2*F+3), .DEN_W(F+3), .Q_W(CMW), .TAG_W(2)) u_div_raw1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_num[1]),
        .i_den   (r_s2_den),
        .i_tag   ({r_s2_ovf[1], r_s2_sgn[1]}),
        .o_valid (),
        .o_quot  (dv1_q[1]),
        .o_tag   (dv1_tag1)
    );

    rmq_div #(.NUM_W(2*F+3), .DEN_W(F+3), .Q_W(CMW), .TAG_W(2)) u_div_raw2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_num[2]),
        .i_den   (r_s2_den),
        .i_tag   ({r_s2_ovf[2], r_s2_sgn[2]}),
        .o_valid (),
        .o_quot  (dv1_q[2]),
        .o_tag   (dv1_tag2)
    );

    // ---------------- Stage 3: saturate and place the components in w, x, y, z order
    logic [CMW-1:0]   raw  [3];
    logic             rsg  [3];
    logic [CMW-1:0]   hq3;
    rmq_pkg::t_branch diag3;
    logic [CMW-1:0]   c_mag [4];
    logic [3:0]       c_sgn;

    assign raw[0] = dv1_tag0[1] ? '1 : dv1_q[0];
    assign raw[1] = dv1_tag1[1] ? '1 : dv1_q[1];
    assign raw[2] = dv1_tag2[1] ? '1 : dv1_q[2];
    assign rsg[0] = dv1_tag0[0];
    assign rsg[1] = dv1_tag1[0];
    assign rsg[2] = dv1_tag2[0];
    assign hq3    = dv1_tag0[T0W-3 -: CMW];
    assign diag3  = rmq_pkg::t_branch'(dv1_tag0[T0W-1 -: 2]);

    always_comb begin
        case (diag3)
            rmq_pkg::BR_TRACE: begin
                c_mag = '{hq3, raw[0], raw[1], raw[2]};
                c_sgn = {rsg[2], rsg[1], rsg[0], 1'b0};
            end
            rmq_pkg::BR_X: begin
                c_mag = '{raw[0], hq3, raw[1], raw[2]};
                c_sgn = {rsg[2], rsg[1], 1'b0, rsg[0]};
            end
            rmq_pkg::BR_Y: begin
                c_mag = '{raw[0], raw[1], hq3, raw[2]};
                c_sgn = {rsg[2], 1'b0, rsg[1], rsg[0]};
            end
            default: begin
                c_mag = '{raw[0], raw[1], raw[2], hq3};
                c_sgn = {1'b0, rsg[2], rsg[1], rsg[0]};
            end
        endcase
    end

    logic [CMW-1:0] r_s3_mag [4];
    logic [3:0]     r_s3_sgn;
    logic           r_s3_sz;
    logic           r_s3_vld;
    logic [SQW-1:0] r_s4_sq  [4];
    logic [CMW-1:0] r_s4_mag [4];
    logic [3:0]     r_s4_sgn;
    logic           r_s4_sz;
    logic           r_s4_vld;
    logic [2*K-1:0] r_s5_sum;
    logic [T2W-1:0] r_s5_tag;
    logic           r_s5_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_mag <= c_mag;
            r_s3_sgn <= c_sgn;
            r_s3_sz  <= dv1_tag0[2];
            // Stage 4: squares of the four magnitudes.
            for (int i = 0; i < 4; i++) begin
                r_s4_sq[i] <= SQW'(r_s3_mag[i]) * SQW'(r_s3_mag[i]);
            end
            r_s4_mag <= r_s3_mag;
            r_s4_sgn <= r_s3_sgn;
            r_s4_sz  <= r_s3_sz;
            // Stage 5: sum of squares.
            r_s5_sum <= (2*K)'(r_s4_sq[0]) + (2*K)'(r_s4_sq[1])
                      + (2*K)'(r_s4_sq[2]) + (2*K)'(r_s4_sq[3]);
            r_s5_tag <= {r_s4_mag[0], r_s4_mag[1], r_s4_mag[2], r_s4_mag[3],
                         r_s4_sgn, r_s4_sz};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= dv1_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    // ---------------- Second square root: the norm
    logic           sq2_vld;
    logic [K-1:0]   sq2_n;
    logic [T2W-1:0] sq2_tag;

    rmq_sqrt #(.K(K), .TAG_W(T2W)) u_sqrt_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s5_vld),
        .i_rad   (r_s5_sum),
        .i_tag   (r_s5_tag),
        .o_valid (sq2_vld),
        .o_root  (sq2_n),
        .o_tag   (sq2_tag)
    );

    // ---------------- Second divider bank: normalized components (c * 2^F) / n
    logic           deg6;
    logic [K-1:0]   den6;
    logic [CMW-1:0] mag6 [4];
    logic [3:0]     sgn6;

    assign deg6 = sq2_tag[0] || (sq2_n == '0);
    assign den6 = (sq2_n == '0) ? K'(1) : sq2_n;
    assign sgn6 = sq2_tag[4:1];

    for (genvar i = 0; i < 4; i++) begin : g_m6
        assign mag6[i] = sq2_tag[T2W-1-i*CMW -: CMW];
    end

    logic [CMW-1:0] dv2_q [4];
    logic [1:0]     dv2_tag0;
    logic           dv2_sg [1:3];
    logic           dv2_vld;

    rmq_div #(.NUM_W(2*F+1), .DEN_W(K), .Q_W(CMW), .TAG_W(2)) u_div_nrm0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq2_vld),
        .i_num   ({mag6[0], {F{1'b0}}}),
        .i_den   (den6),
        .i_tag   ({deg6, sgn6[0]}),
        .o_valid (dv2_vld),
        .o_quot  (dv2_q[0]),
        .o_tag   (dv2_tag0)
    );

    for (genvar i = 1; i < 4; i++) begin : g_dv2
        rmq_div #(.NUM_W(2*F+1), .DEN_W(K), .Q_W(CMW), .TAG_W(1)) u_div_nrm (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq2_vld),
            .i_num   ({mag6[i], {F{1'b0}}}),
            .i_den   (den6),
            .i_tag   (sgn6[i]),
            .o_valid (),
            .o_quot  (dv2_q[i]),
            .o_tag   (dv2_sg[i])
        );
    end

    // ---------------- Output register: sign fix-up and identity substitution
    logic                neg;
    logic                deg7;
    logic signed [F+1:0] vec [1:3];

    assign deg7 = dv2_tag0[1];
    // The whole quaternion flips when the scalar part came out negative.
    assign neg  = dv2_tag0[0] && (dv2_q[0] != '0);

    for (genvar i = 1; i < 4; i++) begin : g_vec
        assign vec[i] = (dv2_sg[i] ^ neg) ? -$signed({1'b0, dv2_q[i]})
                                          :  $signed({1'b0, dv2_q[i]});
    end

    logic        [F:0]   r_out_w;
    logic signed [F+1:0] r_out_x, r_out_y, r_out_z;
    logic                r_out_deg;
    logic                r_out_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_w   <= deg7 ? (F+1)'(ONE_I) : dv2_q[0];
            r_out_x   <= deg7 ? '0 : vec[1];
            r_out_y   <= deg7 ? '0 : vec[2];
            r_out_z   <= deg7 ? '0 : vec[3];
            r_out_deg <= deg7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv2_vld;
        end
    end

    assign en           = !r_out_vld || i_ready;
    assign o_ready      = en;
    assign o_valid      = r_out_vld;
    assign o_quat_w     = r_out_w;
    assign o_quat_x     = r_out_x;
    assign o_quat_y     = r_out_y;
    assign o_quat_z     = r_out_z;
    assign o_degenerate = r_out_deg;

`ifndef ASSERT_OFF
    a_deg_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_quat_w == (F+1)'(ONE_I)
            && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0)
        else $error("degenerate result is not the identity");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_w <= (F+1)'(ONE_I))
        else $error("scalar part above one");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_x <= (F+2)'(ONE_I) && o_quat_x >= -(F+2)'(ONE_I))
        else $error("x part out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s5_vld) && $stable(r_s1_vld))
        else $error("pipeline moved during a stall");
`endif

endmodule
